@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the packet FIFO.
// Each macro expects clk in scope; PFPD_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define PFPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PFPD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pfpd_pkg.sv @@
// Types, codes and defaults for the packet FIFO with partial drain.
// No dependencies; used by every module of the block.
package pfpd_pkg;

    localparam int DEF_SLOTS      = 16;
    localparam int DEF_SLOT_BYTES = 128;
    localparam int MAX_READ       = 64;
    localparam int LEN_W          = 8;
    localparam int CAP_W          = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_TRUNC = 2'd3;

    typedef struct packed {
        logic             command;
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [CAP_W-1:0] capacity;
    } item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             response_last;
        logic             packet_done;
        logic [1:0]       status;
        logic [LEN_W-1:0] committed_length;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_STREAM
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic write;       // write beat accepted
        logic read_empty;  // read accepted on an empty ring
        logic read_start;  // read accepted, head packet present
        logic setup_bad;   // head length not above read offset
        logic setup_go;    // latch count, start streaming
        logic stream;      // streaming bytes of the head packet
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic ring_empty;
        logic len_bad;
        logic last_loaded;
    } dp_status_t;

endpackage

@@ rtl/pfpd_ctrl.sv @@
// Controller state machine of the packet FIFO: input handshake and read sequencing.
// Depends on pfpd_pkg.
module pfpd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  pfpd_pkg::item_t        item,
    input  pfpd_pkg::dp_status_t   stat,
    output pfpd_pkg::ctrl_cmd_t    cmd
);
    import pfpd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   item_fire;
    logic   cap_zero;

    assign item_stall = !(state_reg == ST_IDLE && stat.out_free);
    assign item_fire  = item_valid && !item_stall;
    assign cap_zero   = (item.capacity == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item.command == CMD_READ && !cap_zero && !stat.ring_empty)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = stat.len_bad ? ST_IDLE : ST_STREAM;
            end
            ST_STREAM:
            begin
                if (stat.last_loaded)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.write      = item_fire && item.command == CMD_WRITE;
                cmd.read_empty = item_fire && item.command == CMD_READ && !cap_zero
                                 && stat.ring_empty;
                cmd.read_start = item_fire && item.command == CMD_READ && !cap_zero
                                 && !stat.ring_empty;
            end
            ST_SETUP:
            begin
                cmd.setup_bad = stat.len_bad;
                cmd.setup_go  = !stat.len_bad;
            end
            ST_STREAM:
            begin
                cmd.stream = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/pfpd_datapath.sv @@
// Datapath of the packet FIFO: slot memories, ring pointers, read stream and result register.
// Depends on pfpd_pkg; driven by pfpd_ctrl commands.
module pfpd_datapath #(
    parameter int SLOTS      = pfpd_pkg::DEF_SLOTS,
    parameter int SLOT_BYTES = pfpd_pkg::DEF_SLOT_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfpd_pkg::item_t        item,
    input  pfpd_pkg::ctrl_cmd_t    cmd,
    output pfpd_pkg::dp_status_t   stat,
    input  logic                   result_stall,
    output logic                   result_valid,
    output pfpd_pkg::result_t      result
);
    import pfpd_pkg::*;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int MEM_DEPTH = SLOTS * SLOT_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0] SLOT_STEP    = ADDR_W'(SLOT_BYTES);
    localparam logic [LEN_W-1:0]  SLOT_LEN_MAX = LEN_W'(SLOT_BYTES);
    localparam logic [CNT_W-1:0]  FULL_COUNT   = CNT_W'(SLOTS);
    localparam logic [CAP_W-1:0]  CAP_MAX      = CAP_W'(MAX_READ);

    logic [7:0]       byte_mem [MEM_DEPTH];
    logic [LEN_W-1:0] len_mem  [SLOTS];

    // control state
    logic [SLOT_W-1:0] head_idx_reg,  head_idx_next;
    logic [SLOT_W-1:0] tail_idx_reg,  tail_idx_next;
    logic [ADDR_W-1:0] head_base_reg, head_base_next;
    logic [ADDR_W-1:0] tail_base_reg, tail_base_next;
    logic [CNT_W-1:0]  pkt_cnt_reg,   pkt_cnt_next;
    logic [LEN_W-1:0]  rd_off_reg,    rd_off_next;
    logic [LEN_W-1:0]  fill_cnt_reg,  fill_cnt_next;
    logic              overlong_reg,  overlong_next;
    logic [CAP_W-1:0]  cnt_reg,       cnt_next;
    logic [CAP_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              pend_reg,      pend_next;
    logic              result_valid_reg, result_valid_next;

    // payload
    logic [CAP_W-1:0]  cap_reg,       cap_next;
    logic [LEN_W-1:0]  len_q_reg;
    logic [7:0]        mem_q_reg;
    logic              pend_last_reg, pend_last_next;
    logic              drained_reg,   drained_next;
    logic [ADDR_W-1:0] rd_ptr_reg,    rd_ptr_next;
    result_t           result_reg,    result_next;

    logic              full;
    logic              room;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              commit;
    logic              commit_ok;
    logic [LEN_W-1:0]  commit_len;
    logic              trunc;
    logic [LEN_W-1:0]  len_clamp;
    logic              len_bad;
    logic [LEN_W-1:0]  remain;
    logic              out_free;
    logic              load_out;
    logic              issue;
    logic              last_loaded;
    logic              free_head;

    assign full       = (pkt_cnt_reg == FULL_COUNT);
    assign room       = (fill_cnt_reg < SLOT_LEN_MAX);
    assign wr_en      = cmd.write && room && !full;
    assign wr_addr    = tail_base_reg + ADDR_W'(fill_cnt_reg);
    assign commit     = cmd.write && item.last_byte;
    assign commit_ok  = commit && !full;
    assign commit_len = room ? fill_cnt_reg + LEN_W'(1) : fill_cnt_reg;
    assign trunc      = overlong_reg || !room;

    assign len_clamp  = (len_q_reg > SLOT_LEN_MAX) ? SLOT_LEN_MAX : len_q_reg;
    assign len_bad    = (len_clamp <= rd_off_reg);
    assign remain     = len_clamp - rd_off_reg;

    assign out_free    = !result_valid_reg || !result_stall;
    assign load_out    = cmd.stream && pend_reg && out_free;
    // keep one byte waiting in the read register ahead of the result register
    assign issue       = cmd.stream && (issue_cnt_reg != cnt_reg) && (!pend_reg || load_out);
    assign last_loaded = load_out && pend_last_reg;
    assign free_head   = cmd.setup_bad || (last_loaded && drained_reg);

    assign stat.out_free    = out_free;
    assign stat.ring_empty  = (pkt_cnt_reg == '0);
    assign stat.len_bad     = len_bad;
    assign stat.last_loaded = last_loaded;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        head_idx_next     = head_idx_reg;
        tail_idx_next     = tail_idx_reg;
        head_base_next    = head_base_reg;
        tail_base_next    = tail_base_reg;
        pkt_cnt_next      = pkt_cnt_reg;
        rd_off_next       = rd_off_reg;
        fill_cnt_next     = fill_cnt_reg;
        overlong_next     = overlong_reg;
        cnt_next          = cnt_reg;
        issue_cnt_next    = issue_cnt_reg;
        pend_next         = pend_reg;
        cap_next          = cap_reg;
        pend_last_next    = pend_last_reg;
        drained_next      = drained_reg;
        rd_ptr_next       = rd_ptr_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        // write side: count bytes while there is room and flag the rest as overlong; storing also needs a free slot
        if (cmd.write)
        begin
            if (room)
            begin
                fill_cnt_next = fill_cnt_reg + LEN_W'(1);
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end

        if (commit)
        begin
            fill_cnt_next     = '0;
            overlong_next     = 1'b0;
            result_valid_next = 1'b1;
            result_next       = '0;
            result_next.response_last = 1'b1;
            if (full)
            begin
                result_next.status = STATUS_FULL;
            end
            else
            begin
                result_next.status           = trunc ? STATUS_TRUNC : STATUS_OK;
                result_next.committed_length = commit_len;
                pkt_cnt_next                 = pkt_cnt_reg + CNT_W'(1);
                if (tail_idx_reg == LAST_SLOT)
                begin
                    tail_idx_next  = '0;
                    tail_base_next = '0;
                end
                else
                begin
                    tail_idx_next  = tail_idx_reg + SLOT_W'(1);
                    tail_base_next = tail_base_reg + SLOT_STEP;
                end
            end
        end

        if (cmd.read_empty)
        begin
            result_valid_next         = 1'b1;
            result_next               = '0;
            result_next.response_last = 1'b1;
            result_next.status        = STATUS_EMPTY;
        end

        if (cmd.read_start)
        begin
            cap_next = (item.capacity > CAP_MAX) ? CAP_MAX : item.capacity;
        end

        if (cmd.setup_bad)
        begin
            result_valid_next         = 1'b1;
            result_next               = '0;
            result_next.response_last = 1'b1;
            result_next.packet_done   = 1'b1;
            result_next.status        = STATUS_EMPTY;
        end

        if (cmd.setup_go)
        begin
            // remain fits the count width whenever it is below the capacity
            cnt_next       = (remain < LEN_W'(cap_reg)) ? CAP_W'(remain) : cap_reg;
            drained_next   = (remain <= LEN_W'(cap_reg));
            issue_cnt_next = '0;
            pend_next      = 1'b0;
            rd_ptr_next    = head_base_reg + ADDR_W'(rd_off_reg);
        end

        if (issue)
        begin
            rd_ptr_next    = rd_ptr_reg + ADDR_W'(1);
            issue_cnt_next = issue_cnt_reg + CAP_W'(1);
            pend_last_next = (issue_cnt_reg + CAP_W'(1) == cnt_reg);
            pend_next      = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end

        if (load_out)
        begin
            result_valid_next         = 1'b1;
            result_next               = '0;
            result_next.out_byte      = mem_q_reg;
            result_next.response_last = pend_last_reg;
            result_next.packet_done   = pend_last_reg && drained_reg;
            result_next.status        = STATUS_OK;
        end

        if (last_loaded && !drained_reg)
        begin
            rd_off_next = rd_off_reg + LEN_W'(cnt_reg);
        end

        if (free_head)
        begin
            rd_off_next = '0;
            if (pkt_cnt_reg != '0)
            begin
                pkt_cnt_next = pkt_cnt_reg - CNT_W'(1);
            end
            if (head_idx_reg == LAST_SLOT)
            begin
                head_idx_next  = '0;
                head_base_next = '0;
            end
            else
            begin
                head_idx_next  = head_idx_reg + SLOT_W'(1);
                head_base_next = head_base_reg + SLOT_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx_reg     <= '0;
            tail_idx_reg     <= '0;
            head_base_reg    <= '0;
            tail_base_reg    <= '0;
            pkt_cnt_reg      <= '0;
            rd_off_reg       <= '0;
            fill_cnt_reg     <= '0;
            overlong_reg     <= 1'b0;
            cnt_reg          <= '0;
            issue_cnt_reg    <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_idx_reg     <= head_idx_next;
            tail_idx_reg     <= tail_idx_next;
            head_base_reg    <= head_base_next;
            tail_base_reg    <= tail_base_next;
            pkt_cnt_reg      <= pkt_cnt_next;
            rd_off_reg       <= rd_off_next;
            fill_cnt_reg     <= fill_cnt_next;
            overlong_reg     <= overlong_next;
            cnt_reg          <= cnt_next;
            issue_cnt_reg    <= issue_cnt_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg       <= cap_next;
        pend_last_reg <= pend_last_next;
        drained_reg   <= drained_next;
        rd_ptr_reg    <= rd_ptr_next;
        result_reg    <= result_next;
    end

    // packet byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_mem[wr_addr] <= item.data_byte;
        end
        if (issue)
        begin
            mem_q_reg <= byte_mem[rd_ptr_reg];
        end
    end

    // slot lengths: written at the tail on commit, head entry read every cycle
    always_ff @(posedge clk)
    begin
        if (commit_ok)
        begin
            len_mem[tail_idx_reg] <= commit_len;
        end
        len_q_reg <= len_mem[head_idx_reg];
    end

endmodule

@@ rtl/packet_fifo_partial_drain.sv @@
// Packet FIFO with partial drain. A write beat adds one byte to the packet being
// assembled; the beat flagged last commits the packet into the ring of SLOTS slots
// and answers with one beat carrying the stored length (or a full or truncated
// status). A read beat returns up to capacity bytes (1..64, larger values saturate,
// zero is ignored) of the head packet, one result beat per byte, and leaves the rest
// behind a read offset; the slot frees when its last byte is read. A read holds the
// input while it runs: a setup state covers the registered slot-length read, then the
// registered byte-memory read runs ahead of the result register, one byte per cycle
// while the result side does not stall. An empty ring answers a read with one beat.
// Results are held in an output register, so a new beat is taken in the same cycle
// the previous single-beat answer is accepted.
module packet_fifo_partial_drain #(
    parameter int SLOTS      = pfpd_pkg::DEF_SLOTS,
    parameter int SLOT_BYTES = pfpd_pkg::DEF_SLOT_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  pfpd_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output pfpd_pkg::result_t  result
);
    import pfpd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    pfpd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    pfpd_datapath #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ rtl/pfpd_checker.sv @@
// Port-level checks for the packet FIFO, bound to the top level.
// Depends on pfpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfpd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input pfpd_pkg::item_t    item,
    input logic               result_valid,
    input logic               result_stall,
    input pfpd_pkg::result_t  result
);
    import pfpd_pkg::*;

    logic out_held;
    logic err_beat;
    logic lone_ok;
    logic burst_beat;

    assign out_held   = result_valid && result_stall;
    assign err_beat   = result_valid && result.status != STATUS_OK;
    assign lone_ok    = result.response_last && result.out_byte == 8'd0;
    assign burst_beat = result_valid && !result.response_last;

    `PFPD_ASSERT(a_result_hold, out_held |=> result_valid && $stable(result), "held beat changed")

    // non-ok answers (empty, full, truncated) are single beats with no data byte
    `PFPD_ASSERT(a_status_single, err_beat |-> lone_ok, "non-ok answer not a lone beat")

    // input stays closed while a read response is mid-burst
    `PFPD_ASSERT(a_burst_closed, burst_beat |-> item_stall, "input open during a read burst")

    // next byte of a burst is already waiting when a beat is taken
    `PFPD_ASSERT(a_burst_next, burst_beat && !result_stall |=> result_valid, "gap inside a read burst")

    `PFPD_ASSERT_RST(a_reset_quiet, !rst_n |-> !result_valid, "result valid during reset")

endmodule

bind packet_fifo_partial_drain pfpd_checker u_pfpd_checker (.*);

@@ dv/tb_packet_fifo_partial_drain.sv @@
// Self-checking bench for packet_fifo_partial_drain: directed plan, then random packet traffic.
// Needs pfpd_pkg and the block's RTL; predicts every result beat and checks it field by field.
`timescale 1ns / 1ps

module tb_packet_fifo_partial_drain;
    import pfpd_pkg::*;

    localparam int SLOTS          = DEF_SLOTS;
    localparam int SLOT_BYTES     = DEF_SLOT_BYTES;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int PERIOD         = 8;
    localparam int RANDOM_BEATS   = 220;
    localparam int PLAN_ROWS      = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic             cmd;
        logic [7:0]       data;
        logic             last;
        logic [CAP_W-1:0] cap;
        int               reps;
        bit               typed;
        logic [1:0]       st;
        logic [LEN_W-1:0] len;
    } plan_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predicted FIFO contents and pointers
    logic [7:0]        slot_mem  [SLOTS][SLOT_BYTES];
    bit                byte_known[SLOTS][SLOT_BYTES];
    logic [LEN_W-1:0]  slot_len  [SLOTS];
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W:0]   stored_pkts;
    logic [7:0]        drain_pos;
    logic [7:0]        fill_len;
    bit                overlong;
    bit                dropped_in_pkt;

    result_t   answer_q[$];
    plan_row_t plan[PLAN_ROWS];

    int err_count;
    int n_in, n_out, n_commit, n_trunc, n_full, n_empty, n_partial;
    int send_gap_pct, recv_gap_pct;
    int hold_left;
    int quiet_cycles;
    bit hold_off_req, hold_off_done;

    packet_fifo_partial_drain u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #(PERIOD / 2) clk = ~clk;

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Advance the predicted FIFO by one accepted beat and queue the answers it causes.
    task automatic predict_fifo_answer(input item_t beat);
        result_t     ans;
        bit          full;
        int unsigned cap, remain, count;
        ans = '0;
        if (beat.command == CMD_WRITE) begin
            full = (stored_pkts >= SLOTS);
            if (fill_len < SLOT_BYTES) begin
                // a full ring points the tail at the head slot: count the byte, store nothing
                if (!full) begin
                    slot_mem[wr_slot][fill_len]   = beat.data_byte;
                    byte_known[wr_slot][fill_len] = 1'b1;
                end else begin
                    dropped_in_pkt = 1'b1;
                end
                fill_len++;
            end else begin
                overlong = 1'b1;
            end
            if (beat.last_byte) begin
                ans.response_last = 1'b1;
                if (full) begin
                    ans.status = STATUS_FULL;
                    n_full++;
                end else begin
                    ans.committed_length = fill_len;
                    ans.status           = overlong ? STATUS_TRUNC : STATUS_OK;
                    slot_len[wr_slot]    = fill_len;
                    wr_slot              = SLOT_W'((wr_slot + 1) % SLOTS);
                    stored_pkts++;
                    n_commit++;
                    if (overlong)
                        n_trunc++;
                end
                fill_len       = '0;
                overlong       = 1'b0;
                dropped_in_pkt = 1'b0;
                answer_q.push_back(ans);
            end
        end else if (beat.capacity != 0) begin
            cap = (beat.capacity > MAX_READ) ? MAX_READ : beat.capacity;
            if (stored_pkts == 0) begin
                ans.response_last = 1'b1;
                ans.status        = STATUS_EMPTY;
                n_empty++;
                answer_q.push_back(ans);
            end else if (slot_len[rd_slot] <= drain_pos) begin
                // nothing left behind the offset: free the slot with one empty beat
                ans.response_last = 1'b1;
                ans.packet_done   = 1'b1;
                ans.status        = STATUS_EMPTY;
                rd_slot   = SLOT_W'((rd_slot + 1) % SLOTS);
                stored_pkts--;
                drain_pos = '0;
                answer_q.push_back(ans);
            end else begin
                remain = slot_len[rd_slot] - drain_pos;
                count  = (remain < cap) ? remain : cap;
                for (int unsigned i = 0; i < count; i++) begin
                    ans               = '0;
                    ans.out_byte      = slot_mem[rd_slot][drain_pos + i];
                    ans.response_last = (i + 1 == count);
                    ans.packet_done   = (i + 1 == count) && (count == remain);
                    answer_q.push_back(ans);
                end
                if (count == remain) begin
                    rd_slot   = SLOT_W'((rd_slot + 1) % SLOTS);
                    stored_pkts--;
                    drain_pos = '0;
                end else begin
                    drain_pos += count;
                    n_partial++;
                end
            end
        end
    endtask

    // Offer one beat, hold it until taken, then predict its answers.
    task automatic offer_beat(input item_t beat);
        if ($urandom_range(99) < send_gap_pct) begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        n_in++;
        predict_fifo_answer(beat);
    endtask

    // Result side: check accepted beats, then choose the next stall.
    always @(posedge clk) begin : result_side
        result_t want;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                n_out++;
                if (answer_q.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing expected: %p", result));
                end else begin
                    want = answer_q.pop_front();
                    if (result.out_byte !== want.out_byte)
                        flag_mismatch($sformatf("out_byte %h, want %h",
                                                result.out_byte, want.out_byte));
                    if (result.response_last !== want.response_last)
                        flag_mismatch($sformatf("response_last %b, want %b",
                                                result.response_last, want.response_last));
                    if (result.packet_done !== want.packet_done)
                        flag_mismatch($sformatf("packet_done %b, want %b",
                                                result.packet_done, want.packet_done));
                    if (result.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                result.status, want.status));
                    if (result.committed_length !== want.committed_length)
                        flag_mismatch($sformatf("committed_length %0d, want %0d",
                                                result.committed_length, want.committed_length));
                end
            end
            if (hold_off_req && !hold_off_done) begin
                hold_left     = HOLD_CYCLES;
                hold_off_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end else begin
                result_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_packet_fifo_partial_drain: errors");
            $finish;
        end
    end

    initial begin
        item_t beat;
        int    r, k, n, p, pick, pkt_left, read_pct, remain, eff_cap;
        bit    take_read;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        rd_slot      = '0;
        wr_slot      = '0;
        stored_pkts  = '0;
        drain_pos    = '0;
        fill_len     = '0;
        overlong     = 1'b0;
        dropped_in_pkt = 1'b0;
        send_gap_pct = 13;
        recv_gap_pct = 75;
        pkt_left     = 0;
        read_pct     = 40;

        //         cmd        data   last  cap   reps typed status        len
        plan[0]  = '{CMD_READ,  8'h00, 1'b0, 7'd1,   1, 1'b1, STATUS_EMPTY, 8'd0};
        plan[1]  = '{CMD_WRITE, 8'h00, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,    8'd1};
        plan[2]  = '{CMD_READ,  8'h00, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,    8'd0};
        plan[3]  = '{CMD_READ,  8'h00, 1'b0, 7'd1,   1, 1'b0, STATUS_OK,    8'd0};
        plan[4]  = '{CMD_WRITE, 8'hFF, 1'b0, 7'd127, 4, 1'b0, STATUS_OK,    8'd0};
        plan[5]  = '{CMD_WRITE, 8'h80, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,    8'd5};
        plan[6]  = '{CMD_READ,  8'h00, 1'b0, 7'd2,   1, 1'b0, STATUS_OK,    8'd0};
        plan[7]  = '{CMD_READ,  8'hFF, 1'b1, 7'd127, 1, 1'b0, STATUS_OK,    8'd0};
        plan[8]  = '{CMD_WRITE, 8'h10, 1'b0, 7'd64, 131, 1'b0, STATUS_OK,   8'd0};
        plan[9]  = '{CMD_WRITE, 8'h7F, 1'b1, 7'd0,   1, 1'b1, STATUS_TRUNC, 8'd128};
        plan[10] = '{CMD_READ,  8'h00, 1'b0, 7'd64,  1, 1'b0, STATUS_OK,    8'd0};
        plan[11] = '{CMD_READ,  8'h00, 1'b0, 7'd64,  1, 1'b0, STATUS_OK,    8'd0};
        plan[12] = '{CMD_WRITE, 8'h20, 1'b1, 7'd0,  16, 1'b0, STATUS_OK,    8'd0};
        plan[13] = '{CMD_WRITE, 8'h55, 1'b0, 7'd0,   3, 1'b0, STATUS_OK,    8'd0};
        plan[14] = '{CMD_WRITE, 8'hAA, 1'b1, 7'd0,   1, 1'b1, STATUS_FULL,  8'd0};
        plan[15] = '{CMD_READ,  8'h00, 1'b0, 7'd64, 16, 1'b0, STATUS_OK,    8'd0};
        plan[16] = '{CMD_READ,  8'h00, 1'b0, 7'd64,  1, 1'b1, STATUS_EMPTY, 8'd0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < PLAN_ROWS; r++) begin
            for (k = 0; k < plan[r].reps; k++) begin
                beat.command   = plan[r].cmd;
                beat.data_byte = 8'(plan[r].data + k);
                beat.last_byte = plan[r].last;
                beat.capacity  = plan[r].cap;
                offer_beat(beat);
                if (plan[r].typed) begin
                    // swap the predicted answer for the one written in the plan
                    void'(answer_q.pop_back());
                    beat = '0;
                    answer_q.push_back(result_t'{8'h00, 1'b1, 1'b0, plan[r].st, plan[r].len});
                end
            end
        end

        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(2))
                    0:       read_pct = 20;
                    1:       read_pct = 40;
                    default: read_pct = 65;
                endcase
            end
            if (n == RANDOM_BEATS / 3) begin
                send_gap_pct = 75;
                recv_gap_pct = 13;
            end
            if (n == 2 * RANDOM_BEATS / 3) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
                hold_off_req = 1'b1;
            end
            beat.command   = CMD_WRITE;
            beat.data_byte = 8'($urandom_range(255));
            beat.last_byte = 1'b0;
            beat.capacity  = CAP_W'($urandom_range(127));
            take_read = (pkt_left == 0) ? ($urandom_range(99) < read_pct)
                                        : ($urandom_range(99) < 8);
            if (take_read) begin
                pick = $urandom_range(99);
                if (pick < 4)
                    beat.capacity = '0;
                else if (pick < 10)
                    beat.capacity = CAP_W'($urandom_range(127, 65));
                else if (pick < 55)
                    beat.capacity = CAP_W'($urandom_range(8, 1));
                else
                    beat.capacity = CAP_W'($urandom_range(64, 1));
                // drop a read that would hand the tail a slot with bytes never written
                eff_cap = (beat.capacity > MAX_READ) ? MAX_READ : beat.capacity;
                remain  = slot_len[rd_slot] - drain_pos;
                if (dropped_in_pkt && stored_pkts != 0 && eff_cap != 0 && eff_cap >= remain) begin
                    for (p = 0; p < fill_len; p++)
                        if (!byte_known[rd_slot][p])
                            take_read = 1'b0;
                end
            end
            if (take_read) begin
                beat.command = CMD_READ;
            end else begin
                if (pkt_left == 0)
                    pkt_left = ($urandom_range(99) < 4) ? $urandom_range(150, 129)
                                                        : $urandom_range(24, 1);
                pkt_left--;
                // now and then cut a packet short
                beat.last_byte = (pkt_left == 0) || ($urandom_range(99) < 2);
                if (beat.last_byte)
                    pkt_left = 0;
            end
            offer_beat(beat);
        end
        item_valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats in, %0d out: %0d commits (%0d truncated), %0d dropped on full,",
                 n_in, n_out, n_commit, n_trunc, n_full);
        $display("%0d reads on an empty ring, %0d reads that left bytes behind",
                 n_empty, n_partial);
        if (err_count == 0)
            $display("tb_packet_fifo_partial_drain: clean");
        else
            $display("tb_packet_fifo_partial_drain: errors");
        $finish;
    end

endmodule
